[sv/mspid_pkg.sv]
// Shared types, constants and field layout for the motor speed PID block.
// Depends on nothing; every other file refers to it by scoped names.
package mspid_pkg;

  localparam int DUTY_BITS = 8;
  localparam logic [DUTY_BITS-1:0] DUTY_FULL = '1;

  // Counts per millisecond to RPM in Q16.8: 60 s/min, 1000 ms/s, 256 for the fraction.
  localparam int RPM_SCALE = 60 * 1000 * 256;

  localparam int MUL_W = 33;
  localparam int PROD_W = 2 * MUL_W;

  localparam int DIV_NUM_W = 57;
  localparam int DIV_DEN_W = 48;
  localparam int DIV_CNT_W = 6;
  localparam int DUTY_NUM_W = DUTY_BITS + 24;

  localparam int IN_W = 88;
  localparam int OFS_DIR = DUTY_BITS;
  localparam int OFS_SPEED = DUTY_BITS + 2;
  localparam int OFS_ERR = DUTY_BITS + 26;
  localparam int OFS_VOLT = DUTY_BITS + 50;
  localparam int OFS_CLAMP = DUTY_BITS + 74;
  localparam int OUT_FIELDS_W = DUTY_BITS + 75;
  localparam int OUT_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [31:0] PROP_GAIN_RST = 32'd335544;
  localparam logic [31:0] INTEG_GAIN_RST = 32'd2517;
  localparam logic [31:0] DERIV_GAIN_RST = 32'd0;
  localparam logic [22:0] MAX_VOLTAGE_RST = 23'd393216;
  localparam logic signed [23:0] MIN_VOLTAGE_RST = -24'sd393216;
  localparam logic [15:0] COUNTS_PER_REV_RST = 16'd900;

  localparam logic signed [PROD_W-1:0] S24_MAX = 66'sd8388607;
  localparam logic signed [PROD_W-1:0] S24_MIN = -66'sd8388608;
  localparam logic signed [PROD_W-1:0] TERM_MAX = 66'sd1099511627776;
  localparam logic signed [PROD_W-1:0] TERM_MIN = -66'sd1099511627776;
  localparam logic signed [PROD_W-1:0] INTEG_MAX = 66'sd140737488355327;
  localparam logic signed [PROD_W-1:0] INTEG_MIN = -66'sd140737488355328;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_INTEG_GAIN     = 3'd1,
    REG_DERIV_GAIN     = 3'd2,
    REG_MAX_VOLTAGE    = 3'd3,
    REG_MIN_VOLTAGE    = 3'd4,
    REG_COUNTS_PER_REV = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_COAST = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_REV   = 2'd2
  } dir_t;

  typedef struct packed {
    logic [31:0]        prop_gain;
    logic [31:0]        integ_gain;
    logic [31:0]        deriv_gain;
    logic [22:0]        max_voltage;
    logic signed [23:0] min_voltage;
    logic [15:0]        counts_per_rev;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] encoder_count;
    logic [31:0]        time_ms;
    logic signed [23:0] target_speed;
  } item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] duty;
    dir_t                 direction;
    logic signed [23:0]   measured_speed;
    logic signed [23:0]   speed_error;
    logic signed [23:0]   drive_voltage;
    logic                 clamped;
  } result_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic [DIV_CNT_W-1:0] nbits;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic                 rem_nz;
  } div_rsp_t;

endpackage

[sv/mspid_mul.sv]
// Shared signed multiplier with a registered product.
// Depends on mspid_pkg for the operand width.
module mspid_mul (
  input  logic                                clk,
  input  logic signed [mspid_pkg::MUL_W-1:0]  a,
  input  logic signed [mspid_pkg::MUL_W-1:0]  b,
  output logic signed [mspid_pkg::PROD_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

[sv/mspid_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mspid_pkg for the request and response structs.
module mspid_div (
  input  logic                clk,
  input  logic                rst,
  input  mspid_pkg::div_req_t req,
  output mspid_pkg::div_rsp_t rsp
);

  logic                            busy;
  logic                            done;
  logic [mspid_pkg::DIV_CNT_W-1:0] cnt;
  logic [mspid_pkg::DIV_NUM_W-1:0] num_sh;
  logic [mspid_pkg::DIV_NUM_W-1:0] quot;
  logic [mspid_pkg::DIV_DEN_W-1:0] den_r;
  logic [mspid_pkg::DIV_DEN_W-1:0] rem;
  logic [mspid_pkg::DIV_DEN_W:0]   trial;
  logic [mspid_pkg::DIV_DEN_W:0]   diff;
  logic                            fits;

  assign trial = {rem, num_sh[mspid_pkg::DIV_NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - mspid_pkg::DIV_CNT_W'(1);
        if (cnt == mspid_pkg::DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= req.num;
      den_r  <= req.den;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= num_sh << 1;
      rem    <= fits ? diff[mspid_pkg::DIV_DEN_W-1:0] : trial[mspid_pkg::DIV_DEN_W-1:0];
      quot   <= {quot[mspid_pkg::DIV_NUM_W-2:0], fits};
    end
  end

  assign rsp.done   = done;
  assign rsp.quot   = quot;
  assign rsp.rem_nz = |rem;

endmodule

[sv/mspid_core.sv]
// Sequencer and datapath registers of the speed controller.
// Depends on mspid_pkg, mspid_mul and mspid_div.
module mspid_core (
  input  logic               clk,
  input  logic               rst,
  input  mspid_pkg::cfg_t    cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  mspid_pkg::item_t   in_item,
  output logic               res_valid,
  input  logic               res_ready,
  output mspid_pkg::result_t res
);

  typedef enum logic [20:0] {
    S_IDLE      = 21'h000001,
    S_DT        = 21'h000002,
    S_MUL_SPD   = 21'h000004,
    S_MUL_CD    = 21'h000008,
    S_DIVS_GO   = 21'h000010,
    S_DIVS_WAIT = 21'h000020,
    S_ERR       = 21'h000040,
    S_SUMS      = 21'h000080,
    S_MUL_INT   = 21'h000100,
    S_MUL_P     = 21'h000200,
    S_MUL_IHI   = 21'h000400,
    S_MUL_ILO   = 21'h000800,
    S_MUL_D     = 21'h001000,
    S_DIVD_GO   = 21'h002000,
    S_DIVD_WAIT = 21'h004000,
    S_SUMV      = 21'h008000,
    S_CLAMP     = 21'h010000,
    S_MUL_DUTY  = 21'h020000,
    S_DIVY_GO   = 21'h040000,
    S_DIVY_WAIT = 21'h080000,
    S_DONE      = 21'h100000
  } state_t;

  state_t state, state_next;

  logic signed [31:0] count_r;
  logic [31:0]        now_r;
  logic signed [23:0] target_r;
  logic [31:0]        dt_r;
  logic [31:0]        dt_c;
  logic signed [31:0] delta_r;

  logic signed [31:0] last_count;
  logic [31:0]        last_time;
  logic signed [23:0] last_error;
  logic signed [47:0] err_int;

  logic                            num_neg_r;
  logic [mspid_pkg::DIV_NUM_W-1:0] num_mag_r;
  logic                            div_neg_r;
  logic signed [23:0]              speed_r;
  logic signed [23:0]              err_r;
  logic signed [24:0]              esum_r;
  logic signed [24:0]              ediff_r;
  logic signed [47:0]              integ_r;
  logic signed [41:0]              tp_r;
  logic signed [41:0]              ti_r;
  logic signed [41:0]              td_r;
  logic signed [mspid_pkg::PROD_W-1:0] tiacc_r;
  logic signed [42:0]              v_r;
  logic signed [23:0]              vout_r;
  logic                            clamp_r;
  logic [mspid_pkg::DUTY_BITS-1:0] duty_r;

  logic signed [mspid_pkg::MUL_W-1:0]  mul_a;
  logic signed [mspid_pkg::MUL_W-1:0]  mul_b;
  logic signed [mspid_pkg::PROD_W-1:0] prod;
  logic [mspid_pkg::PROD_W-1:0]        prod_abs;

  mspid_pkg::div_req_t div_req;
  mspid_pkg::div_rsp_t div_rsp;

  logic [mspid_pkg::DIV_NUM_W:0]        q_ext;
  logic signed [mspid_pkg::DIV_NUM_W:0] div_floor;
  logic [23:0]                          vmag;
  logic [15:0]                          cpr_eff;
  logic signed [42:0]                   vmax;
  logic signed [42:0]                   vmin;
  logic signed [42:0]                   v_hi;
  logic                                 clamp_hi;
  logic                                 clamp_lo;
  logic                                 vmax_zero;

  function automatic logic signed [mspid_pkg::PROD_W-1:0] sat66(
    input logic signed [mspid_pkg::PROD_W-1:0] x,
    input logic signed [mspid_pkg::PROD_W-1:0] lo,
    input logic signed [mspid_pkg::PROD_W-1:0] hi
  );
    if (x < lo) begin
      return lo;
    end else if (x > hi) begin
      return hi;
    end
    return x;
  endfunction

  mspid_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  mspid_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign dt_c      = now_r - last_time;
  assign cpr_eff   = (cfg.counts_per_rev == 16'd0) ? 16'd1 : cfg.counts_per_rev;
  assign prod_abs  = prod[mspid_pkg::PROD_W-1] ? (~prod + mspid_pkg::PROD_W'(1)) : prod;
  assign q_ext     = {1'b0, div_rsp.quot};
  assign div_floor = div_neg_r
                   ? $signed(~q_ext + (div_rsp.rem_nz ? '0 : (mspid_pkg::DIV_NUM_W + 1)'(1)))
                   : $signed(q_ext);
  assign vmag      = vout_r[23] ? (~vout_r + 24'd1) : vout_r;
  assign vmax      = 43'(cfg.max_voltage);
  assign vmin      = 43'($signed(cfg.min_voltage));
  assign clamp_hi  = v_r > vmax;
  assign v_hi      = clamp_hi ? vmax : v_r;
  assign clamp_lo  = v_hi < vmin;
  assign vmax_zero = cfg.max_voltage == 23'd0;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_SPD: begin
        mul_a = 33'(delta_r);
        mul_b = 33'(mspid_pkg::RPM_SCALE);
      end
      S_MUL_CD: begin
        mul_a = 33'(cpr_eff);
        mul_b = 33'(dt_r);
      end
      S_MUL_INT: begin
        mul_a = 33'(dt_r);
        mul_b = 33'(esum_r);
      end
      S_MUL_P: begin
        mul_a = 33'(cfg.prop_gain);
        mul_b = 33'(err_r);
      end
      S_MUL_IHI: begin
        mul_a = 33'(cfg.integ_gain);
        mul_b = 33'($signed(integ_r[47:16]));
      end
      S_MUL_ILO: begin
        mul_a = 33'(cfg.integ_gain);
        mul_b = 33'(integ_r[15:0]);
      end
      S_MUL_D: begin
        mul_a = 33'(cfg.deriv_gain);
        mul_b = 33'(ediff_r);
      end
      S_MUL_DUTY: begin
        mul_a = 33'(mspid_pkg::DUTY_FULL);
        mul_b = 33'(vmag);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    div_req = '0;
    case (state)
      S_DIVS_GO: begin
        div_req.start = 1'b1;
        div_req.num   = num_mag_r;
        div_req.den   = prod[mspid_pkg::DIV_DEN_W-1:0];
        div_req.nbits = mspid_pkg::DIV_CNT_W'(mspid_pkg::DIV_NUM_W);
      end
      S_DIVD_GO: begin
        div_req.start = 1'b1;
        div_req.num   = prod_abs[mspid_pkg::DIV_NUM_W-1:0];
        div_req.den   = {dt_r, 16'd0};
        div_req.nbits = mspid_pkg::DIV_CNT_W'(mspid_pkg::DIV_NUM_W);
      end
      S_DIVY_GO: begin
        div_req.start = !vmax_zero;
        div_req.num   = {prod_abs[mspid_pkg::DUTY_NUM_W-1:0],
                         {(mspid_pkg::DIV_NUM_W - mspid_pkg::DUTY_NUM_W){1'b0}}};
        div_req.den   = mspid_pkg::DIV_DEN_W'(cfg.max_voltage);
        div_req.nbits = mspid_pkg::DIV_CNT_W'(mspid_pkg::DUTY_NUM_W);
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:      if (in_valid) state_next = S_DT;
      S_DT:        state_next = (dt_c == 32'd0) ? S_IDLE : S_MUL_SPD;
      S_MUL_SPD:   state_next = S_MUL_CD;
      S_MUL_CD:    state_next = S_DIVS_GO;
      S_DIVS_GO:   state_next = S_DIVS_WAIT;
      S_DIVS_WAIT: if (div_rsp.done) state_next = S_ERR;
      S_ERR:       state_next = S_SUMS;
      S_SUMS:      state_next = S_MUL_INT;
      S_MUL_INT:   state_next = S_MUL_P;
      S_MUL_P:     state_next = S_MUL_IHI;
      S_MUL_IHI:   state_next = S_MUL_ILO;
      S_MUL_ILO:   state_next = S_MUL_D;
      S_MUL_D:     state_next = S_DIVD_GO;
      S_DIVD_GO:   state_next = S_DIVD_WAIT;
      S_DIVD_WAIT: if (div_rsp.done) state_next = S_SUMV;
      S_SUMV:      state_next = S_CLAMP;
      S_CLAMP:     state_next = S_MUL_DUTY;
      S_MUL_DUTY:  state_next = S_DIVY_GO;
      S_DIVY_GO:   state_next = vmax_zero ? S_DONE : S_DIVY_WAIT;
      S_DIVY_WAIT: if (div_rsp.done) state_next = S_DONE;
      S_DONE:      if (res_ready) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_count <= '0;
      last_time  <= '0;
      last_error <= '0;
      err_int    <= '0;
    end else begin
      state <= state_next;
      if (state == S_DONE && res_ready) begin
        last_count <= count_r;
        last_time  <= now_r;
        last_error <= err_r;
        if (!clamp_r) begin
          err_int <= integ_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        count_r  <= in_item.encoder_count;
        now_r    <= in_item.time_ms;
        target_r <= in_item.target_speed;
      end
      S_DT: begin
        dt_r    <= dt_c;
        delta_r <= count_r - last_count;
      end
      S_MUL_CD: begin
        num_neg_r <= prod[mspid_pkg::PROD_W-1];
        num_mag_r <= prod_abs[mspid_pkg::DIV_NUM_W-1:0];
      end
      S_DIVS_GO: div_neg_r <= num_neg_r;
      S_DIVS_WAIT: begin
        if (div_rsp.done) begin
          speed_r <= 24'(sat66(66'(div_floor), mspid_pkg::S24_MIN, mspid_pkg::S24_MAX));
        end
      end
      S_ERR: begin
        err_r <= 24'(sat66(66'(target_r) - 66'(speed_r), mspid_pkg::S24_MIN,
                           mspid_pkg::S24_MAX));
      end
      S_SUMS: begin
        esum_r  <= 25'(err_r) + 25'(last_error);
        ediff_r <= 25'(err_r) - 25'(last_error);
      end
      S_MUL_P: begin
        integ_r <= 48'(sat66(66'(err_int) + (prod >>> 1), mspid_pkg::INTEG_MIN,
                             mspid_pkg::INTEG_MAX));
      end
      S_MUL_IHI: tp_r <= $signed(prod[57:16]);
      S_MUL_ILO: tiacc_r <= prod;
      S_MUL_D: begin
        ti_r <= 42'(sat66(tiacc_r + (prod >>> 16), mspid_pkg::TERM_MIN, mspid_pkg::TERM_MAX));
      end
      S_DIVD_GO: div_neg_r <= prod[mspid_pkg::PROD_W-1];
      S_DIVD_WAIT: begin
        if (div_rsp.done) begin
          td_r <= 42'(sat66(66'(div_floor), mspid_pkg::TERM_MIN, mspid_pkg::TERM_MAX));
        end
      end
      S_SUMV: v_r <= 43'(tp_r) + 43'(ti_r) + 43'(td_r);
      S_CLAMP: begin
        vout_r  <= clamp_lo ? vmin[23:0] : v_hi[23:0];
        clamp_r <= clamp_hi | clamp_lo;
      end
      S_DIVY_GO: begin
        if (vmax_zero) begin
          duty_r <= (vmag != 24'd0) ? mspid_pkg::DUTY_FULL : '0;
        end
      end
      S_DIVY_WAIT: begin
        if (div_rsp.done) begin
          duty_r <= (div_rsp.quot > mspid_pkg::DIV_NUM_W'(mspid_pkg::DUTY_FULL))
                  ? mspid_pkg::DUTY_FULL : div_rsp.quot[mspid_pkg::DUTY_BITS-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready  = state == S_IDLE;
  assign res_valid = state == S_DONE;

  always_comb begin
    res.duty           = duty_r;
    res.direction      = (vout_r > 24'sd0) ? mspid_pkg::DIR_FWD
                       : (vout_r[23] ? mspid_pkg::DIR_REV : mspid_pkg::DIR_COAST);
    res.measured_speed = speed_r;
    res.speed_error    = err_r;
    res.drive_voltage  = vout_r;
    res.clamped        = clamp_r;
  end

endmodule

[sv/motor_speed_pid_with_antiwindup_top.sv]
// Top level of the motor speed PID controller with anti-windup.
// Depends on mspid_pkg and mspid_core; holds the register file and output stage.
//
// Each transaction on the s_axis channel is one control tick: encoder count,
// millisecond timestamp and target speed. When the timestamp equals the previous
// accepted one, the tick is absorbed and no result follows. Otherwise one result
// transaction appears on m_axis: duty, direction, measured speed, speed error,
// clamped drive voltage and the clamp flag.
// The work for a tick is three passes through the one-bit-per-cycle divider
// (speed, derivative term, duty; the duty pass is skipped when max_voltage is
// zero) plus eight uses of the shared 33 by 33 multiplier. A tick with no
// elapsed time frees the input without a result. s_axis_tready is high only
// while the sequencer is idle.
// A finished result sits in the output register; the next tick is accepted while
// it waits. If the receiver stalls, the following result is held inside until
// the register frees. Reset clears the controller history and restores the
// register defaults. The user writes registers through cfg_wen, cfg_index and
// cfg_wdata only while no tick is in flight; the block does not enforce this.
module motor_speed_pid_with_antiwindup_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // encoder_count, time_ms, target_speed
  input  logic [mspid_pkg::IN_W-1:0]          s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // duty, direction, measured_speed, speed_error, drive_voltage, clamped
  output logic [mspid_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic                                cfg_wen,
  input  logic [mspid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mspid_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  mspid_pkg::cfg_t    cfg;
  mspid_pkg::item_t   in_item;
  mspid_pkg::result_t res;
  logic               res_valid;
  logic               res_ready;
  logic               ovalid;
  logic [mspid_pkg::OUT_W-1:0] odata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prop_gain      <= mspid_pkg::PROP_GAIN_RST;
      cfg.integ_gain     <= mspid_pkg::INTEG_GAIN_RST;
      cfg.deriv_gain     <= mspid_pkg::DERIV_GAIN_RST;
      cfg.max_voltage    <= mspid_pkg::MAX_VOLTAGE_RST;
      cfg.min_voltage    <= mspid_pkg::MIN_VOLTAGE_RST;
      cfg.counts_per_rev <= mspid_pkg::COUNTS_PER_REV_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        mspid_pkg::REG_PROP_GAIN:      cfg.prop_gain      <= cfg_wdata;
        mspid_pkg::REG_INTEG_GAIN:     cfg.integ_gain     <= cfg_wdata;
        mspid_pkg::REG_DERIV_GAIN:     cfg.deriv_gain     <= cfg_wdata;
        mspid_pkg::REG_MAX_VOLTAGE:    cfg.max_voltage    <= cfg_wdata[22:0];
        mspid_pkg::REG_MIN_VOLTAGE:    cfg.min_voltage    <= cfg_wdata[23:0];
        mspid_pkg::REG_COUNTS_PER_REV: cfg.counts_per_rev <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.encoder_count = $signed(s_axis_tdata[31:0]);
    in_item.time_ms       = s_axis_tdata[63:32];
    in_item.target_speed  = $signed(s_axis_tdata[87:64]);
  end

  mspid_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_item   (in_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !ovalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (res_ready) begin
      ovalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      odata <= mspid_pkg::OUT_W'({res.clamped, res.drive_voltage, res.speed_error,
                                  res.measured_speed, res.direction, res.duty});
    end
  end

  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata  = odata;

endmodule

[sv/mspid_checker.sv]
// Port-level checks for the motor speed PID top level, attached by bind.
// Depends on mspid_pkg for the result field layout.
module mspid_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [mspid_pkg::OUT_W-1:0] m_axis_tdata
);

  logic [mspid_pkg::DUTY_BITS-1:0] duty;
  logic [1:0]                      dir;
  logic [23:0]                     volt;

  assign duty    = m_axis_tdata[mspid_pkg::DUTY_BITS-1:0];
  assign dir     = m_axis_tdata[mspid_pkg::OFS_DIR +: 2];
  assign volt    = m_axis_tdata[mspid_pkg::OFS_VOLT +: 24];

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("Result valid straight after reset.");

  a_output_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result transaction changed.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("Input taken again straight after a transaction.");

  a_direction_matches_voltage: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((dir == mspid_pkg::DIR_COAST) == (volt == 24'd0)) &&
                      ((dir == mspid_pkg::DIR_REV) == volt[23]))
    else $error("Direction code disagrees with the drive voltage.");

  a_coast_gives_zero_duty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && dir == mspid_pkg::DIR_COAST |-> duty == '0)
    else $error("Coasting result with a nonzero duty.");

endmodule

bind motor_speed_pid_with_antiwindup_top mspid_checker u_mspid_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
